// ===== sv/nioc_pkg.sv =====
// Shared types, constants and helpers for the N-d index/offset converter.
`timescale 1ns / 1ps
package nioc_pkg;

  localparam int MAX_DIMS     = 3;
  localparam int DEF_NUM_DIMS = 3;
  localparam int DIM_W        = $clog2(MAX_DIMS);
  localparam int IDX_W        = 16;
  localparam int OFF_W        = 48;
  localparam int EXT_W        = IDX_W + 1;
  localparam int DIV_BITS     = 4;
  localparam int DIV_STEPS    = OFF_W / DIV_BITS;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = IDX_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_MAJOR = 3'd0,
    REG_LOWER_0   = 3'd1,
    REG_LOWER_1   = 3'd2,
    REG_LOWER_2   = 3'd3,
    REG_UPPER_0   = 3'd4,
    REG_UPPER_1   = 3'd5,
    REG_UPPER_2   = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    ACT_TO_OFFSET = 1'b0,
    ACT_TO_INDEX  = 1'b1
  } action_e;

  typedef struct packed {
    logic                    action;
    logic signed [IDX_W-1:0] index_in_0;
    logic signed [IDX_W-1:0] index_in_1;
    logic signed [IDX_W-1:0] index_in_2;
    logic        [OFF_W-1:0] offset_in;
  } in_t;

  typedef struct packed {
    logic        [OFF_W-1:0] offset_out;
    logic signed [IDX_W-1:0] index_out_0;
    logic signed [IDX_W-1:0] index_out_1;
    logic signed [IDX_W-1:0] index_out_2;
  } out_t;

  // Everything is kept in visiting order (fastest dimension at position 0).
  typedef struct packed {
    logic                                act;
    logic [MAX_DIMS-1:0][IDX_W-1:0]      idx_pos;
    logic [OFF_W-1:0]                    acc;
    logic [OFF_W-1:0]                    w;
    logic [EXT_W-1:0]                    r;
    logic [MAX_DIMS-1:0][IDX_W-1:0]      rem;
  } pipe_t;

  typedef struct packed {
    logic                           row_major;
    logic [MAX_DIMS-1:0][EXT_W-1:0] ext_pos;
    logic [MAX_DIMS-1:0][IDX_W-1:0] lo_pos;
  } cfg_t;

  // Dimension visited at a position, fastest first.
  function automatic logic [DIM_W-1:0] dim_at(input logic row_major,
                                              input logic [DIM_W-1:0] pos,
                                              input logic [DIM_W-1:0] last);
    return row_major ? DIM_W'(last - pos) : pos;
  endfunction

endpackage

// ===== sv/nioc_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps
interface nioc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/nioc_cfg.sv =====
// Configuration registers, extents and the position-ordered view of the box.
`timescale 1ns / 1ps
module nioc_cfg
  import nioc_pkg::*;
#(
  parameter int NUM_DIMS = DEF_NUM_DIMS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic                           row_major_q;
  logic [MAX_DIMS-1:0][IDX_W-1:0] lo_q;
  logic [MAX_DIMS-1:0][IDX_W-1:0] hi_q;
  logic [MAX_DIMS-1:0][EXT_W-1:0] ext_q;
  logic [MAX_DIMS-1:0][EXT_W-1:0] ext_d;

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      if ($signed(hi_q[d]) < $signed(lo_q[d])) begin
        ext_d[d] = EXT_W'(1);
      end else begin
        ext_d[d] = {hi_q[d][IDX_W-1], hi_q[d]} - {lo_q[d][IDX_W-1], lo_q[d]} + EXT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_major_q <= 1'b1;
      lo_q        <= '0;
      hi_q        <= '0;
      ext_q       <= {MAX_DIMS{EXT_W'(1)}};
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_ROW_MAJOR: row_major_q <= cfg_data_i[0];
          REG_LOWER_0:   lo_q[0]     <= cfg_data_i;
          REG_LOWER_1:   lo_q[1]     <= cfg_data_i;
          REG_LOWER_2:   lo_q[2]     <= cfg_data_i;
          REG_UPPER_0:   hi_q[0]     <= cfg_data_i;
          REG_UPPER_1:   hi_q[1]     <= cfg_data_i;
          REG_UPPER_2:   hi_q[2]     <= cfg_data_i;
          default: ;
        endcase
      end
      ext_q <= ext_d;
    end
  end

  always_comb begin
    cfg_o           = '0;
    cfg_o.row_major = row_major_q;
    for (int p = 0; p < NUM_DIMS; p++) begin
      cfg_o.ext_pos[p] = ext_q[dim_at(row_major_q, DIM_W'(p), DIM_W'(NUM_DIMS - 1))];
      cfg_o.lo_pos[p]  = lo_q[dim_at(row_major_q, DIM_W'(p), DIM_W'(NUM_DIMS - 1))];
    end
  end

endmodule

// ===== sv/nioc_mac_stage.sv =====
// One Horner step of the offset sum: acc = acc * extent + (index - lower).
`timescale 1ns / 1ps
module nioc_mac_stage
  import nioc_pkg::*;
#(
  parameter int POS = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  pipe_t            data_i,
  input  logic [EXT_W-1:0] ext_i,
  input  logic [IDX_W-1:0] lo_i,
  output logic             valid_o,
  output pipe_t            data_o
);

  logic             valid_q;
  pipe_t            data_q;
  pipe_t            data_d;
  logic [EXT_W-1:0] diff;
  logic [OFF_W+EXT_W-1:0] prod;

  always_comb begin
    diff        = {data_i.idx_pos[POS][IDX_W-1], data_i.idx_pos[POS]} - {lo_i[IDX_W-1], lo_i};
    prod        = data_i.acc * ext_i;
    data_d      = data_i;
    data_d.acc  = prod[OFF_W-1:0] + {{(OFF_W-EXT_W){diff[EXT_W-1]}}, diff};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/nioc_div_stage.sv =====
// Four bits of restoring division of the running offset by one extent.
`timescale 1ns / 1ps
module nioc_div_stage
  import nioc_pkg::*;
#(
  parameter int POS  = 0,
  parameter bit LAST = 1'b0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  pipe_t            data_i,
  input  logic [EXT_W-1:0] ext_i,
  output logic             valid_o,
  output pipe_t            data_o
);

  logic             valid_q;
  pipe_t            data_q;
  pipe_t            data_d;
  logic [OFF_W-1:0] w;
  logic [EXT_W-1:0] r;
  logic [EXT_W-1:0] r2;
  logic             q;

  always_comb begin
    w  = data_i.w;
    r  = data_i.r;
    r2 = '0;
    q  = 1'b0;
    for (int b = 0; b < DIV_BITS; b++) begin
      r2 = {r[EXT_W-2:0], w[OFF_W-1]};
      q  = (r2 >= ext_i);
      r  = q ? (r2 - ext_i) : r2;
      w  = {w[OFF_W-2:0], q};
    end
    data_d   = data_i;
    data_d.w = w;
    data_d.r = r;
    // At the end of a dimension the quotient carries on and the remainder is kept.
    if (LAST) begin
      data_d.rem[POS] = r[IDX_W-1:0];
      data_d.r        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/nioc_out_buf.sv =====
// Result formatting, output register and skid register.
`timescale 1ns / 1ps
module nioc_out_buf
  import nioc_pkg::*;
#(
  parameter int NUM_DIMS = DEF_NUM_DIMS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  pipe_t data_i,
  input  cfg_t  cfg_i,
  output logic  en_o,
  nioc_stream_if.source res_o
);

  out_t res_d;
  out_t out_q;
  out_t skid_q;
  logic out_v_q;
  logic skid_v_q;
  logic [MAX_DIMS-1:0][IDX_W-1:0] idx;
  logic [DIM_W-1:0] d;

  always_comb begin
    idx = '0;
    d   = '0;
    if (data_i.act == ACT_TO_INDEX) begin
      for (int p = 0; p < NUM_DIMS; p++) begin
        d      = dim_at(cfg_i.row_major, DIM_W'(p), DIM_W'(NUM_DIMS - 1));
        idx[d] = cfg_i.lo_pos[p] + data_i.rem[p];
      end
    end
    res_d.offset_out  = (data_i.act == ACT_TO_OFFSET) ? data_i.acc : '0;
    res_d.index_out_0 = idx[0];
    res_d.index_out_1 = idx[1];
    res_d.index_out_2 = idx[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || res_o.ready) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= valid_i;
      end
    end else if (valid_i && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || res_o.ready) begin
      out_q <= skid_v_q ? skid_q : res_d;
    end else if (!skid_v_q) begin
      skid_q <= res_d;
    end
  end

  assign en_o        = !skid_v_q;
  assign res_o.valid = out_v_q;
  assign res_o.data  = out_q;

endmodule

// ===== sv/nd_index_offset_converter_unit.sv =====
// Top level of the N-d index/offset converter.
//
// Converts a box index (index_in_*) to its linear offset, or an offset back to
// indices, in row- or column-major order as set by the configuration port.
// Items enter on inp_i and leave on res_o; both are valid/ready channels and a
// beat moves when valid and ready are high at a rising edge. Every item gives
// exactly one result beat.
// The pipeline accepts one beat per cycle while its skid register is empty.
// Its stages are one input register, one multiply-add stage per dimension,
// twelve 4-bit divider stages per dimension, and the output register. A
// configuration write updates its register and the derived extents follow in
// the cycle after; writes are made while the pipeline is empty, which the block
// does not enforce. Reset restores row-major order and zero bounds and empties
// the pipeline. When the receiver stalls, one more result is caught in a skid
// register and the whole pipeline then holds; nothing is dropped or repeated.
`timescale 1ns / 1ps
module nd_index_offset_converter_unit
  import nioc_pkg::*;
#(
  parameter int NUM_DIMS = DEF_NUM_DIMS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  nioc_stream_if.sink           inp_i,
  nioc_stream_if.source         res_o
);

  localparam int NUM_STAGES = 1 + NUM_DIMS + NUM_DIMS * DIV_STEPS;

  cfg_t  cfg;
  logic  en;
  logic  [NUM_STAGES-1:0] stage_v;
  pipe_t stage_d [NUM_STAGES];
  logic  in_v_q;
  pipe_t in_q;
  pipe_t in_d;
  logic [MAX_DIMS-1:0][IDX_W-1:0] idx_in;

  nioc_cfg #(.NUM_DIMS(NUM_DIMS)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign inp_i.ready = en;

  always_comb begin
    idx_in[0]  = inp_i.data.index_in_0;
    idx_in[1]  = inp_i.data.index_in_1;
    idx_in[2]  = inp_i.data.index_in_2;
    in_d       = '0;
    in_d.act   = inp_i.data.action;
    in_d.w     = inp_i.data.offset_in;
    for (int p = 0; p < NUM_DIMS; p++) begin
      in_d.idx_pos[p] = idx_in[dim_at(cfg.row_major, DIM_W'(p), DIM_W'(NUM_DIMS - 1))];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= inp_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_d;
    end
  end

  assign stage_v[0] = in_v_q;
  assign stage_d[0] = in_q;

  // Offset sum, slowest dimension first.
  for (genvar h = 0; h < NUM_DIMS; h++) begin : g_mac
    nioc_mac_stage #(.POS(NUM_DIMS - 1 - h)) u_mac (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (stage_v[h]),
      .data_i  (stage_d[h]),
      .ext_i   (cfg.ext_pos[NUM_DIMS - 1 - h]),
      .lo_i    (cfg.lo_pos[NUM_DIMS - 1 - h]),
      .valid_o (stage_v[h + 1]),
      .data_o  (stage_d[h + 1])
    );
  end

  // Remainders, fastest dimension first.
  for (genvar p = 0; p < NUM_DIMS; p++) begin : g_dim
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int S = 1 + NUM_DIMS + p * DIV_STEPS + k;
      nioc_div_stage #(.POS(p), .LAST(k == DIV_STEPS - 1)) u_div (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (stage_v[S - 1]),
        .data_i  (stage_d[S - 1]),
        .ext_i   (cfg.ext_pos[p]),
        .valid_o (stage_v[S]),
        .data_o  (stage_d[S])
      );
    end
  end

  nioc_out_buf #(.NUM_DIMS(NUM_DIMS)) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_v[NUM_STAGES - 1]),
    .data_i  (stage_d[NUM_STAGES - 1]),
    .cfg_i   (cfg),
    .en_o    (en),
    .res_o   (res_o)
  );

endmodule

// ===== tb/nd_index_offset_converter_unit_test.sv =====
// Self-checking testbench for the N-d index/offset converter unit.
`timescale 1ns / 1ps
module nd_index_offset_converter_unit_test;
  import nioc_pkg::*;

  localparam int PIPE_LATENCY = 2 + DEF_NUM_DIMS * 13;
  localparam int IDLE_LIMIT   = 20000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  nioc_stream_if #(.T(in_t))  inp_if ();
  nioc_stream_if #(.T(out_t)) res_if ();

  nd_index_offset_converter_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .inp_i     (inp_if.sink),
    .res_o     (res_if.source)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the configuration registers.
  logic                  shadow_row_major;
  logic signed [IDX_W-1:0] shadow_lower [MAX_DIMS];
  logic signed [IDX_W-1:0] shadow_upper [MAX_DIMS];

  out_t pending_results [$];
  int   mismatch_count = 0;
  int   result_count = 0;
  int   item_count = 0;
  int   idle_cycles = 0;
  bit   hold_off = 1'b0;

  initial begin
    inp_if.valid = 1'b0;
    inp_if.data  = '0;
    res_if.ready = 1'b0;
  end

  function automatic longint dim_extent(int d);
    longint lo, hi;
    lo = shadow_lower[d];
    hi = shadow_upper[d];
    return (hi < lo) ? 1 : hi - lo + 1;
  endfunction

  function automatic out_t convert_item(in_t item);
    out_t   res;
    longint diff;
    logic [63:0] step, acc, rem, ext;
    logic signed [IDX_W-1:0] idx [MAX_DIMS];
    int d;
    res = '0;
    idx[0] = item.index_in_0;
    idx[1] = item.index_in_1;
    idx[2] = item.index_in_2;
    step = 64'd1;
    acc = 64'd0;
    rem = {16'd0, item.offset_in};
    for (int pos = 0; pos < DEF_NUM_DIMS; pos++) begin
      d = shadow_row_major ? DEF_NUM_DIMS - 1 - pos : pos;
      ext = dim_extent(d);
      if (item.action == ACT_TO_OFFSET) begin
        diff = longint'(idx[d]) - longint'(shadow_lower[d]);
        acc = (acc + step * diff) & 64'hFFFF_FFFF_FFFF;
        step = (step * ext) & 64'hFFFF_FFFF_FFFF;
      end else begin
        idx[d] = shadow_lower[d] + IDX_W'(rem % ext);
        rem = rem / ext;
      end
    end
    if (item.action == ACT_TO_OFFSET) res.offset_out = acc[OFF_W-1:0];
    else begin
      res.index_out_0 = idx[0];
      res.index_out_1 = idx[1];
      res.index_out_2 = idx[2];
    end
    return res;
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    int wait_left;
    if (hold_off) begin
      res_if.ready <= 1'b0;
    end else if (wait_left > 0) begin
      wait_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      out_t exp_res;
      result_count++;
      wait_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 1) == 0) wait_left = 0;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat %p", res_if.data);
      end else begin
        exp_res = pending_results.pop_front();
        if (res_if.data.offset_out !== exp_res.offset_out ||
            res_if.data.index_out_0 !== exp_res.index_out_0 ||
            res_if.data.index_out_1 !== exp_res.index_out_1 ||
            res_if.data.index_out_2 !== exp_res.index_out_2) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p, got %p", exp_res, res_if.data);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk_i) begin
    if ((inp_if.valid && inp_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Valid stays high from one beat to the next when there is no gap; drain drops it.
  task automatic send_item(in_t item, bit no_gap = 1'b0);
    int gap;
    gap = ($urandom_range(0, 2) == 0 || no_gap) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      inp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    inp_if.valid <= 1'b1;
    inp_if.data  <= item;
    do @(posedge clk_i); while (!inp_if.ready);
    pending_results = {pending_results, convert_item(item)};
    item_count++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_ROW_MAJOR: shadow_row_major = value[0];
      REG_LOWER_0:   shadow_lower[0] = value;
      REG_LOWER_1:   shadow_lower[1] = value;
      REG_LOWER_2:   shadow_lower[2] = value;
      REG_UPPER_0:   shadow_upper[0] = value;
      REG_UPPER_1:   shadow_upper[1] = value;
      REG_UPPER_2:   shadow_upper[2] = value;
      default: ;
    endcase
  endtask

  task automatic drain;
    inp_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic set_box(bit row_major, int lo0, int hi0, int lo1, int hi1,
                         int lo2, int hi2);
    drain();
    write_reg(REG_ROW_MAJOR, CFG_DATA_W'(row_major));
    write_reg(REG_LOWER_0, CFG_DATA_W'(lo0));
    write_reg(REG_UPPER_0, CFG_DATA_W'(hi0));
    write_reg(REG_LOWER_1, CFG_DATA_W'(lo1));
    write_reg(REG_UPPER_1, CFG_DATA_W'(hi1));
    write_reg(REG_LOWER_2, CFG_DATA_W'(lo2));
    write_reg(REG_UPPER_2, CFG_DATA_W'(hi2));
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_t random_item(bit mostly_inside);
    in_t item;
    longint vol;
    item.action = action_e'($urandom_range(0, 1));
    item.index_in_0 = IDX_W'($urandom);
    item.index_in_1 = IDX_W'($urandom);
    item.index_in_2 = IDX_W'($urandom);
    item.offset_in = OFF_W'({$urandom, $urandom});
    if (mostly_inside && $urandom_range(0, 3) != 0) begin
      item.index_in_0 = shadow_lower[0] + IDX_W'($urandom_range(0, dim_extent(0) - 1));
      item.index_in_1 = shadow_lower[1] + IDX_W'($urandom_range(0, dim_extent(1) - 1));
      item.index_in_2 = shadow_lower[2] + IDX_W'($urandom_range(0, dim_extent(2) - 1));
      vol = dim_extent(0) * dim_extent(1) * dim_extent(2);
      if (vol > 64'hFFFF_FFFF) item.offset_in = OFF_W'({$urandom, $urandom}) % OFF_W'(vol);
      else item.offset_in = OFF_W'($urandom_range(0, 32'(vol - 1)));
    end
    return item;
  endfunction

  task automatic test_reset_defaults;
    in_t item;
    item = '0;
    send_item(item);
    item.action = ACT_TO_INDEX;
    item.offset_in = 48'd12345;
    send_item(item);
  endtask

  task automatic test_directed_extremes;
    in_t item;
    set_box(1'b1, -32768, 32767, -5, 4, 10, 13);
    item = '0;
    item.index_in_0 = IDX_W'(-32768); item.index_in_1 = IDX_W'(-5);
    item.index_in_2 = IDX_W'(10);
    send_item(item);
    item.index_in_0 = IDX_W'(32767); item.index_in_1 = IDX_W'(4);
    item.index_in_2 = IDX_W'(13);
    send_item(item);
    // Indices outside the box wrap the offset.
    item.index_in_0 = IDX_W'(-32768); item.index_in_1 = IDX_W'(32767);
    item.index_in_2 = IDX_W'(-32768);
    send_item(item);
    item = '0;
    item.action = ACT_TO_INDEX;
    item.offset_in = '0;
    send_item(item);
    item.offset_in = '1;
    send_item(item);
    item.offset_in = 48'h0000_0009_FFFF;
    send_item(item);
    // Column-major with inverted bounds in dimensions 0 and 1.
    set_box(1'b0, 32767, -32768, 100, -100, -32768, -32768);
    item = '0;
    item.index_in_0 = IDX_W'(32767); item.index_in_1 = IDX_W'(100);
    item.index_in_2 = IDX_W'(-32768);
    send_item(item);
    item.index_in_0 = IDX_W'(-1); item.index_in_1 = IDX_W'(0);
    item.index_in_2 = IDX_W'(32767);
    send_item(item);
    item = '0;
    item.action = ACT_TO_INDEX;
    item.offset_in = 48'h8000_0000_0001;
    send_item(item);
    item.offset_in = 48'h7FFF_FFFF_FFFF;
    send_item(item);
  endtask

  task automatic test_random_boxes(int count);
    int lo [MAX_DIMS];
    int span [MAX_DIMS];
    for (int b = 0; b < 6; b++) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        lo[d] = $signed(16'($urandom));
        span[d] = (b == 5) ? $urandom_range(0, 65535) : $urandom_range(0, 20);
        if ($urandom_range(0, 9) == 0) span[d] = -1 - $urandom_range(0, 50);
      end
      set_box(1'($urandom_range(0, 1)), lo[0], lo[0] + span[0], lo[1], lo[1] + span[1],
              lo[2], lo[2] + span[2]);
      for (int n = 0; n < count / 6; n++) send_item(random_item(1'b1));
    end
  endtask

  // The receiver stops while the sender keeps the input full.
  task automatic test_back_pressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (150) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 80; n++) send_item(random_item(1'b0), 1'b1);
    join
  endtask

  initial begin
    shadow_row_major = 1'b1;
    for (int d = 0; d < MAX_DIMS; d++) begin
      shadow_lower[d] = '0;
      shadow_upper[d] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_extremes();
    test_random_boxes(660);
    test_back_pressure();
    drain();
    $display("Sent %0d items over directed, random-box and back-pressure phases;",
             item_count);
    $display("checked %0d result beats, %0d mismatches.", result_count, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/nioc_pkg.sv
sv/nioc_stream_if.sv
sv/nioc_cfg.sv
sv/nioc_mac_stage.sv
sv/nioc_div_stage.sv
sv/nioc_out_buf.sv
sv/nd_index_offset_converter_unit.sv
tb/nd_index_offset_converter_unit_test.sv
